// ----- design/amg_pkg.sv -----
// ----------------------------------------------------------------------------
// amg_pkg
// Shared types and constants for the adjacency matrix graph store.
// ----------------------------------------------------------------------------
package amg_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int IDX_W            = 7;
    localparam int CMP_W            = 8;

    typedef enum logic [2:0] {
        CMD_CREATE   = 3'd0,
        CMD_ADD_VTX  = 3'd1,
        CMD_REM_VTX  = 3'd2,
        CMD_ADD_EDGE = 3'd3,
        CMD_REM_EDGE = 3'd4,
        CMD_QUERY    = 3'd5
    } t_cmd_code;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RD_NONE  = 2'd0,
        RD_A     = 2'd1,
        RD_B     = 2'd2,
        RD_SWEEP = 2'd3
    } t_rd_sel;

    typedef enum logic [2:0] {
        WB_NONE  = 3'd0,
        WB_SET   = 3'd1,
        WB_CLR   = 3'd2,
        WB_SHIFT = 3'd3,
        WB_ZERO  = 3'd4,
        WB_PEEK  = 3'd5
    } t_wb_kind;

    typedef enum logic [1:0] {
        CNT_KEEP = 2'd0,
        CNT_LOAD = 2'd1,
        CNT_INC  = 2'd2,
        CNT_DEC  = 2'd3
    } t_cnt_op;

    typedef struct packed {
        logic             item_load;
        t_rd_sel          rd_sel;
        t_wb_kind         wb_kind;
        t_cnt_op          cnt_op;
        logic             clr_all;
        logic             st_load;
        t_status          st_val;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] cmd;
        logic       a_ok;
        logic       b_ok;
        logic       cnt_zero;
        logic       cnt_full;
        logic       new_big;
        logic       sweep_last;
        logic       out_free;
    } t_dp_stat;

endpackage

// ----- design/amg_if.sv -----
// ----------------------------------------------------------------------------
// amg_if
// Valid/ready channels carrying command items in and result items out.
// ----------------------------------------------------------------------------
interface amg_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [4:0] vertex_a;
    logic [4:0] vertex_b;
    logic [5:0] new_count;

    modport source (output valid, output command, output vertex_a, output vertex_b,
                    output new_count, input ready);
    modport sink   (input valid, input command, input vertex_a, input vertex_b,
                    input new_count, output ready);
endinterface

interface amg_out_if;
    logic       valid;
    logic       ready;
    logic       adjacent;
    logic [5:0] vertex_count;
    logic [1:0] status;

    modport source (output valid, output adjacent, output vertex_count, output status,
                    input ready);
    modport sink   (input valid, input adjacent, input vertex_count, input status,
                    output ready);
endinterface

// ----- design/amg_dpath.sv -----
// ----------------------------------------------------------------------------
// amg_dpath
// Row memory, valid bits, vertex count, item and result registers.
// ----------------------------------------------------------------------------
module amg_dpath import amg_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [2:0] i_command,
    input  logic [4:0] i_vertex_a,
    input  logic [4:0] i_vertex_b,
    input  logic [5:0] i_new_count,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    input  logic       i_ready,
    output logic       o_valid,
    output logic       o_adjacent,
    output logic [5:0] o_vertex_count,
    output logic [1:0] o_status
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [2:0]              r_cmd;
    logic [4:0]              r_va;
    logic [4:0]              r_vb;
    logic [5:0]              r_nc;
    logic [CW-1:0]           r_count;
    t_status                 r_status;
    logic                    r_adj;

    logic [MAX_VERTICES-1:0] r_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_vld;
    logic [MAX_VERTICES-1:0] r_rd_row;
    t_wb_kind                r_wb_kind;
    logic [AW-1:0]           r_wb_dst;
    logic [4:0]              r_wb_bit;

    logic                    r_out_vld;
    logic                    r_out_adj;
    logic [5:0]              r_out_cnt;
    t_status                 r_out_st;

    logic [CMP_W-1:0]        w_a;
    logic [CMP_W-1:0]        w_b;
    logic [CMP_W-1:0]        w_n;
    logic [CMP_W-1:0]        w_nc;
    logic [CMP_W-1:0]        w_max;
    logic [CMP_W-1:0]        w_idx;
    logic [CMP_W-1:0]        w_src;
    logic                    src_ok;
    logic [AW-1:0]           rd_addr;
    t_wb_kind                n_wb_kind;
    logic [AW-1:0]           n_wb_dst;
    logic [4:0]              n_wb_bit;
    logic [MAX_VERTICES-1:0] n_row;
    logic                    wr_en;

    assign w_a    = CMP_W'(r_va);
    assign w_b    = CMP_W'(r_vb);
    assign w_n    = CMP_W'(r_count);
    assign w_nc   = CMP_W'(r_nc);
    assign w_max  = CMP_W'(MAX_VERTICES);
    assign w_idx  = CMP_W'(i_cmd.idx);
    assign w_src  = (w_idx < w_a) ? w_idx : w_idx + CMP_W'(1);
    assign src_ok = w_src < w_n;

    assign o_stat.cmd        = r_cmd;
    assign o_stat.a_ok       = w_a < w_n;
    assign o_stat.b_ok       = w_b < w_n;
    assign o_stat.cnt_zero   = w_n == '0;
    assign o_stat.cnt_full   = w_n == w_max;
    assign o_stat.new_big    = w_nc > w_max;
    assign o_stat.sweep_last = (w_idx + CMP_W'(1)) == w_n;
    assign o_stat.out_free   = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_cmd <= i_command;
            r_va  <= i_vertex_a;
            r_vb  <= i_vertex_b;
            r_nc  <= i_new_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            unique case (i_cmd.cnt_op)
                CNT_LOAD: r_count <= CW'(r_nc);
                CNT_INC:  r_count <= r_count + CW'(1);
                CNT_DEC:  r_count <= r_count - CW'(1);
                default:  r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.st_load) begin
            r_status <= i_cmd.st_val;
        end
    end

    always_comb begin
        rd_addr   = AW'(r_va);
        n_wb_kind = i_cmd.wb_kind;
        n_wb_dst  = AW'(r_va);
        n_wb_bit  = r_vb;
        unique case (i_cmd.rd_sel)
            RD_B: begin
                rd_addr  = AW'(r_vb);
                n_wb_dst = AW'(r_vb);
                n_wb_bit = r_va;
            end
            RD_SWEEP: begin
                rd_addr  = AW'(w_src);
                n_wb_dst = AW'(i_cmd.idx);
                n_wb_bit = r_va;
                if (!src_ok) begin
                    n_wb_kind = WB_ZERO;
                end
            end
            default: begin
                rd_addr = AW'(r_va);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_row <= r_vld[rd_addr] ? r_mem[rd_addr] : '0;
        r_wb_dst <= n_wb_dst;
        r_wb_bit <= n_wb_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_kind <= WB_NONE;
        end else begin
            r_wb_kind <= n_wb_kind;
        end
    end

    always_comb begin
        n_row = '0;
        wr_en = 1'b0;
        unique case (r_wb_kind)
            WB_SET: begin
                wr_en                  = 1'b1;
                n_row                  = r_rd_row;
                n_row[AW'(r_wb_bit)]   = 1'b1;
            end
            WB_CLR: begin
                wr_en                  = 1'b1;
                n_row                  = r_rd_row;
                n_row[AW'(r_wb_bit)]   = 1'b0;
            end
            WB_SHIFT: begin
                wr_en = 1'b1;
                for (int j = 0; j < MAX_VERTICES; j++) begin
                    if (j < int'(r_wb_bit)) begin
                        n_row[j] = r_rd_row[j];
                    end else if (j + 1 < MAX_VERTICES) begin
                        n_row[j] = r_rd_row[j + 1];
                    end else begin
                        n_row[j] = 1'b0;
                    end
                end
            end
            WB_ZERO: begin
                wr_en = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wb_dst] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.clr_all) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[r_wb_dst] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wb_kind == WB_PEEK) begin
            r_adj <= r_rd_row[AW'(r_wb_bit)] & o_stat.a_ok & o_stat.b_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_adj <= r_adj;
            r_out_cnt <= 6'(r_count);
            r_out_st  <= r_status;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_adjacent     = r_out_adj;
    assign o_vertex_count = r_out_cnt;
    assign o_status       = r_out_st;

endmodule

// ----- design/amg_ctrl.sv -----
// ----------------------------------------------------------------------------
// amg_ctrl
// Command sequencer: checks each item, steps row reads and writes, hands off
// the result.
// ----------------------------------------------------------------------------
module amg_ctrl import amg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DECIDE = 11'b000_0000_0010,
        S_RD_A   = 11'b000_0000_0100,
        S_GAP_A  = 11'b000_0000_1000,
        S_RD_B   = 11'b000_0001_0000,
        S_GAP_B  = 11'b000_0010_0000,
        S_SWEEP  = 11'b000_0100_0000,
        S_DRAIN  = 11'b000_1000_0000,
        S_PEEK   = 11'b001_0000_0000,
        S_WAIT   = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    t_wb_kind         edge_kind;

    assign edge_kind = (i_stat.cmd == CMD_ADD_EDGE) ? WB_SET : WB_CLR;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_ready = 1'b0;

        o_cmd           = '0;
        o_cmd.rd_sel    = RD_NONE;
        o_cmd.wb_kind   = WB_NONE;
        o_cmd.cnt_op    = CNT_KEEP;
        o_cmd.st_val    = ST_OK;
        o_cmd.idx       = r_idx;

        unique case (r_state)
            S_IDLE: begin
                o_ready         = 1'b1;
                o_cmd.item_load = i_valid;
                if (i_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.st_load = 1'b1;
                n_state       = S_PEEK;
                unique case (i_stat.cmd) inside
                    CMD_CREATE: begin
                        if (i_stat.new_big) begin
                            o_cmd.st_val = ST_FULL;
                        end else begin
                            o_cmd.cnt_op  = CNT_LOAD;
                            o_cmd.clr_all = 1'b1;
                        end
                    end
                    CMD_ADD_VTX: begin
                        if (i_stat.cnt_full) begin
                            o_cmd.st_val = ST_FULL;
                        end else begin
                            o_cmd.cnt_op = CNT_INC;
                        end
                    end
                    CMD_REM_VTX: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.st_val = ST_FULL;
                        end else if (!i_stat.a_ok) begin
                            o_cmd.st_val = ST_RANGE;
                        end else begin
                            n_idx   = '0;
                            n_state = S_SWEEP;
                        end
                    end
                    CMD_ADD_EDGE, CMD_REM_EDGE: begin
                        if (!(i_stat.a_ok && i_stat.b_ok)) begin
                            o_cmd.st_val = ST_RANGE;
                        end else begin
                            n_state = S_RD_A;
                        end
                    end
                    CMD_QUERY: begin
                        if (!(i_stat.a_ok && i_stat.b_ok)) begin
                            o_cmd.st_val = ST_RANGE;
                        end
                    end
                    default: begin
                        o_cmd.st_val = ST_RANGE;
                    end
                endcase
            end
            S_RD_A: begin
                o_cmd.rd_sel  = RD_A;
                o_cmd.wb_kind = edge_kind;
                n_state       = S_GAP_A;
            end
            S_GAP_A: begin
                n_state = S_RD_B;
            end
            S_RD_B: begin
                o_cmd.rd_sel  = RD_B;
                o_cmd.wb_kind = edge_kind;
                n_state       = S_GAP_B;
            end
            S_GAP_B: begin
                n_state = S_PEEK;
            end
            S_SWEEP: begin
                o_cmd.rd_sel  = RD_SWEEP;
                o_cmd.wb_kind = WB_SHIFT;
                if (i_stat.sweep_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                o_cmd.cnt_op = CNT_DEC;
                n_state      = S_PEEK;
            end
            S_PEEK: begin
                o_cmd.rd_sel  = RD_A;
                o_cmd.wb_kind = WB_PEEK;
                n_state       = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

// ----- design/adjacency_matrix_graph_store.sv -----
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store
// Undirected graph held as a symmetric adjacency bit matrix with a live
// vertex count; one command item in, one result item out.
// ----------------------------------------------------------------------------
// The matrix sits in a row memory with per-row valid bits, so one row is
// read and one row written per cycle. Each item is processed to its result
// before the next is accepted; add or remove edge makes two row updates,
// and vertex removal sweeps every live row once, compacting rows and
// dropping the removed column. A finished result waits in the output
// register while the next item is taken. Create clears the matrix at once
// through the valid bits; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store import amg_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    amg_in_if.sink    i_in,
    amg_out_if.source o_out
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    amg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    amg_dpath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_command      (i_in.command),
        .i_vertex_a     (i_in.vertex_a),
        .i_vertex_b     (i_in.vertex_b),
        .i_new_count    (i_in.new_count),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_ready        (o_out.ready),
        .o_valid        (o_out.valid),
        .o_adjacent     (o_out.adjacent),
        .o_vertex_count (o_out.vertex_count),
        .o_status       (o_out.status)
    );

endmodule

// ----- dv/adjacency_matrix_graph_store_tb.sv -----
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store_tb
// Self-checking bench for the graph store: a directed table of boundary and
// error commands, then random command streams biased towards valid indices,
// run under several sender and receiver idling patterns. Every result item
// is compared with typed table values or a local model of matrix and count.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store_tb import amg_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV               = MAX_VERTICES_DEF;
    localparam int DIR_ROWS         = 25;
    localparam int RANDOM_PER_PHASE = 425;
    localparam int NUM_PHASES       = 4;
    localparam int DRAIN_CYCLES     = 64;
    localparam int CYCLE_LIMIT      = 600000;

    localparam logic [2:0] CMD_UNKNOWN_6 = 3'd6;
    localparam logic [2:0] CMD_UNKNOWN_7 = 3'd7;

    typedef struct packed {
        logic [2:0] command;
        logic [4:0] vertex_a;
        logic [4:0] vertex_b;
        logic [5:0] new_count;
    } t_graph_cmd;

    typedef struct packed {
        logic       adjacent;
        logic [5:0] vertex_count;
        t_status    status;
    } t_graph_rsp;

    typedef struct packed {
        logic [2:0] command;
        logic [4:0] vertex_a;
        logic [4:0] vertex_b;
        logic [5:0] new_count;
        logic       typed;
        logic       adjacent;
        logic [5:0] vertex_count;
        t_status    status;
    } t_dir_row;

    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{CMD_QUERY,     5'd0,  5'd0,  6'd0,  1'b1, 1'b0, 6'd0,  ST_RANGE},
        '{CMD_REM_VTX,   5'd0,  5'd0,  6'd0,  1'b1, 1'b0, 6'd0,  ST_FULL},
        '{CMD_CREATE,    5'd0,  5'd0,  6'd33, 1'b1, 1'b0, 6'd0,  ST_FULL},
        '{CMD_CREATE,    5'd31, 5'd31, 6'd63, 1'b1, 1'b0, 6'd0,  ST_FULL},
        '{CMD_CREATE,    5'd31, 5'd31, 6'd32, 1'b1, 1'b0, 6'd32, ST_OK},
        '{CMD_ADD_VTX,   5'd0,  5'd0,  6'd0,  1'b1, 1'b0, 6'd32, ST_FULL},
        '{CMD_ADD_EDGE,  5'd31, 5'd0,  6'd0,  1'b0, 1'b0, 6'd0,  ST_OK},
        '{CMD_ADD_EDGE,  5'd31, 5'd31, 6'd0,  1'b0, 1'b0, 6'd0,  ST_OK},
        '{CMD_ADD_EDGE,  5'd0,  5'd0,  6'd0,  1'b0, 1'b0, 6'd0,  ST_OK},
        '{CMD_QUERY,     5'd0,  5'd31, 6'd0,  1'b0, 1'b0, 6'd0,  ST_OK},
        '{CMD_REM_EDGE,  5'd0,  5'd31, 6'd0,  1'b0, 1'b0, 6'd0,  ST_OK},
        '{CMD_QUERY,     5'd31, 5'd31, 6'd0,  1'b0, 1'b0, 6'd0,  ST_OK},
        '{CMD_REM_VTX,   5'd31, 5'd0,  6'd0,  1'b0, 1'b0, 6'd0,  ST_OK},
        '{CMD_REM_VTX,   5'd31, 5'd0,  6'd0,  1'b1, 1'b0, 6'd31, ST_RANGE},
        '{CMD_ADD_EDGE,  5'd31, 5'd0,  6'd0,  1'b1, 1'b0, 6'd31, ST_RANGE},
        '{CMD_REM_EDGE,  5'd0,  5'd31, 6'd0,  1'b1, 1'b0, 6'd31, ST_RANGE},
        '{CMD_QUERY,     5'd5,  5'd31, 6'd0,  1'b1, 1'b0, 6'd31, ST_RANGE},
        '{CMD_UNKNOWN_6, 5'd0,  5'd0,  6'd0,  1'b0, 1'b0, 6'd0,  ST_OK},
        '{CMD_UNKNOWN_7, 5'd31, 5'd31, 6'd63, 1'b1, 1'b0, 6'd31, ST_RANGE},
        '{CMD_REM_VTX,   5'd0,  5'd0,  6'd0,  1'b0, 1'b0, 6'd0,  ST_OK},
        '{CMD_CREATE,    5'd0,  5'd0,  6'd0,  1'b1, 1'b0, 6'd0,  ST_OK},
        '{CMD_ADD_VTX,   5'd0,  5'd0,  6'd0,  1'b1, 1'b0, 6'd1,  ST_OK},
        '{CMD_ADD_EDGE,  5'd0,  5'd0,  6'd0,  1'b0, 1'b0, 6'd0,  ST_OK},
        '{CMD_REM_VTX,   5'd0,  5'd0,  6'd0,  1'b1, 1'b0, 6'd0,  ST_OK},
        '{CMD_CREATE,    5'd30, 5'd0,  6'd31, 1'b0, 1'b0, 6'd0,  ST_OK}
    };

    localparam int SEND_IDLE_PCT  [NUM_PHASES] = '{0, 82, 0, 31};
    localparam int RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 82, 31};

    logic clk;
    logic rst_n;

    amg_in_if  in_ch ();
    amg_out_if out_ch ();

    adjacency_matrix_graph_store u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [NV-1:0] adj_rows [NV];
    int            live_cnt;
    t_graph_rsp    rsp_q [$];

    int send_idle_pct;
    int recv_stall_pct;
    int err_cnt;
    int cycle_cnt = 0;
    int n_items;
    int n_rejected;
    int n_removals;
    int n_checked;
    int peak_cnt;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_graph_rsp apply_graph_cmd(t_graph_cmd c);
        t_graph_rsp    r;
        t_status       st;
        int            a;
        int            b;
        int            n;
        int            i;
        logic [NV-1:0] lo_mask;
        a  = c.vertex_a;
        b  = c.vertex_b;
        n  = live_cnt;
        st = ST_OK;
        case (c.command) inside
            CMD_CREATE: begin
                if (c.new_count > NV) begin
                    st = ST_FULL;
                end else begin
                    for (i = 0; i < NV; i++) adj_rows[i] = '0;
                    live_cnt = c.new_count;
                end
            end
            CMD_ADD_VTX: begin
                if (n >= NV) st = ST_FULL;
                else         live_cnt = n + 1;
            end
            CMD_REM_VTX: begin
                if (n == 0) begin
                    st = ST_FULL;
                end else if (a >= n) begin
                    st = ST_RANGE;
                end else begin
                    for (i = a; i + 1 < n; i++) adj_rows[i] = adj_rows[i + 1];
                    adj_rows[n - 1] = '0;
                    live_cnt = n - 1;
                    lo_mask  = (NV'(1) << a) - NV'(1);
                    for (i = 0; i < n - 1; i++) begin
                        adj_rows[i] = (adj_rows[i] & lo_mask) |
                                      ((adj_rows[i] >> (a + 1)) << a);
                    end
                end
            end
            CMD_ADD_EDGE, CMD_REM_EDGE: begin
                if (a >= n || b >= n) begin
                    st = ST_RANGE;
                end else if (c.command == CMD_ADD_EDGE) begin
                    adj_rows[a][b] = 1'b1;
                    adj_rows[b][a] = 1'b1;
                end else begin
                    adj_rows[a][b] = 1'b0;
                    adj_rows[b][a] = 1'b0;
                end
            end
            CMD_QUERY: begin
                if (a >= n || b >= n) st = ST_RANGE;
            end
            default: st = ST_RANGE;
        endcase
        r.adjacent     = (a < live_cnt && b < live_cnt) ? adj_rows[a][b] : 1'b0;
        r.vertex_count = 6'(live_cnt);
        r.status       = st;
        return r;
    endfunction

    function automatic logic [4:0] pick_vertex();
        if (live_cnt > 0 && $urandom_range(99) < 85) return 5'($urandom_range(live_cnt - 1));
        return 5'($urandom_range(31));
    endfunction

    function automatic t_graph_cmd gen_random_cmd();
        t_graph_cmd c;
        int         pick;
        int         sz;
        pick        = $urandom_range(99);
        c.vertex_a  = pick_vertex();
        c.vertex_b  = pick_vertex();
        c.new_count = 6'($urandom_range(63));
        if (pick < 4) begin
            c.command = CMD_CREATE;
            sz = $urandom_range(99);
            if (sz < 12)      c.new_count = 6'(NV);
            else if (sz < 22) c.new_count = 6'($urandom_range(63, NV + 1));
            else if (sz < 27) c.new_count = 6'd0;
            else              c.new_count = 6'($urandom_range(NV - 1, 1));
        end else if (pick < 6) begin
            c.command = $urandom_range(1) ? CMD_UNKNOWN_7 : CMD_UNKNOWN_6;
        end else if (pick < 18) begin
            c.command = CMD_ADD_VTX;
        end else if (pick < 28) begin
            c.command = CMD_REM_VTX;
        end else if (pick < 60) begin
            c.command = CMD_ADD_EDGE;
        end else if (pick < 75) begin
            c.command = CMD_REM_EDGE;
        end else begin
            c.command = CMD_QUERY;
        end
        return c;
    endfunction

    task automatic drive_cmd(input t_graph_cmd c, input logic typed, input t_graph_rsp typed_rsp);
        t_graph_rsp pred;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= c.command;
        in_ch.vertex_a  <= c.vertex_a;
        in_ch.vertex_b  <= c.vertex_b;
        in_ch.new_count <= c.new_count;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        pred = apply_graph_cmd(c);
        rsp_q.push_back(typed ? typed_rsp : pred);
        n_items++;
        if (pred.status != ST_OK) n_rejected++;
        else if (c.command == CMD_REM_VTX) n_removals++;
        if (live_cnt > peak_cnt) peak_cnt = live_cnt;
    endtask

    task automatic check_result();
        t_graph_rsp exp_rsp;
        if (rsp_q.size() == 0) begin
            $error("result item with no command outstanding");
            err_cnt++;
            return;
        end
        exp_rsp = rsp_q.pop_front();
        n_checked++;
        if (out_ch.adjacent !== exp_rsp.adjacent) begin
            $error("adjacent: expected %0d, actual %0d", exp_rsp.adjacent, out_ch.adjacent);
            err_cnt++;
        end
        if (out_ch.vertex_count !== exp_rsp.vertex_count) begin
            $error("vertex_count: expected %0d, actual %0d",
                   exp_rsp.vertex_count, out_ch.vertex_count);
            err_cnt++;
        end
        if (out_ch.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, out_ch.status);
            err_cnt++;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) check_result();
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, rsp_q.size());
            $display("adjacency_matrix_graph_store_tb: FAIL");
            $finish;
        end
    end

    initial begin
        t_graph_cmd c;
        t_graph_rsp r;
        int         ph;
        int         k;
        err_cnt         = 0;
        n_items         = 0;
        n_rejected      = 0;
        n_removals      = 0;
        n_checked       = 0;
        peak_cnt        = 0;
        live_cnt        = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        for (k = 0; k < NV; k++) adj_rows[k] = '0;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.command   <= CMD_CREATE;
        in_ch.vertex_a  <= '0;
        in_ch.vertex_b  <= '0;
        in_ch.new_count <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++) begin
            c.command      = DIR_TABLE[k].command;
            c.vertex_a     = DIR_TABLE[k].vertex_a;
            c.vertex_b     = DIR_TABLE[k].vertex_b;
            c.new_count    = DIR_TABLE[k].new_count;
            r.adjacent     = DIR_TABLE[k].adjacent;
            r.vertex_count = DIR_TABLE[k].vertex_count;
            r.status       = DIR_TABLE[k].status;
            drive_cmd(c, DIR_TABLE[k].typed, r);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct  = SEND_IDLE_PCT[ph];
            recv_stall_pct = RECV_STALL_PCT[ph];
            for (k = 0; k < RANDOM_PER_PHASE; k++) begin
                drive_cmd(gen_random_cmd(), 1'b0, '0);
            end
        end
        in_ch.valid <= 1'b0;

        while (rsp_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d command items: %0d rejected, %0d vertex removals, peak count %0d",
                 n_items, n_rejected, n_removals, peak_cnt);
        $display("%0d results checked under four sender and receiver idling patterns",
                 n_checked);
        if (err_cnt == 0) begin
            $display("adjacency_matrix_graph_store_tb: PASS");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("adjacency_matrix_graph_store_tb: FAIL");
        end
        $finish;
    end

endmodule
